@@ rtl/gsq_pkg.sv @@
// Shared types and constants for the biped gait sequencer.
package gsq_pkg;

  localparam int ANGLE_W = 15;
  localparam int LIMIT_W = 16;
  localparam int HIP_W   = 16;
  localparam int CNT_W   = 16;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 15'd328;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd200;

  // register index, taken from paddr[2]
  localparam logic REG_TRANS_ANGLE  = 1'b0;
  localparam logic REG_FLIGHT_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    PH_SETUP     = 3'd0,
    PH_OUT_SWING = 3'd1,
    PH_OUT_PUSH  = 3'd2,
    PH_INN_SWING = 3'd3,
    PH_INN_PUSH  = 3'd4,
    PH_FLIGHT    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ANK_HOLD = 2'd0,
    ANK_PUSH = 2'd1,
    ANK_FLIP = 2'd2
  } ankle_t;

  typedef enum logic [2:0] {
    HIP_ZERO          = 3'd0,
    HIP_SCISSOR_OUTER = 3'd1,
    HIP_PLUS_HOLD     = 3'd2,
    HIP_SCISSOR_INNER = 3'd3,
    HIP_MINUS_HOLD    = 3'd4
  } hip_mode_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] transition_angle;
    logic [LIMIT_W-1:0] flight_limit;
  } cfg_t;

  typedef struct packed {
    logic                    inner_foot_down;
    logic                    outer_foot_down;
    logic signed [HIP_W-1:0] hip_angle;
  } item_t;

  typedef struct packed {
    phase_t    gait_phase;
    ankle_t    outer_ankle_mode;
    ankle_t    inner_ankle_mode;
    hip_mode_t hip_mode;
    logic      motors_enabled;
    logic      gyro_fix;
  } result_t;

endpackage

@@ rtl/biped_gait_sequencer_unit.sv @@
// Top level of the biped gait sequencer: input register, tick logic, result register.
// A request waits in the input register, then moves into the result register.
// Throughput: one request per cycle while the result is taken; the phase and
// airborne counter update in the cycle the request moves into the result register.
// An empty input stage accepts while a finished result still waits downstream.
// Reset (rst, synchronous, active high): both stages empty, phase setup,
// counter zero, transition_angle 328, flight_limit 200.
module biped_gait_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [0] inner_foot_down, [1] outer_foot_down, [17:2] hip_angle, [23:18] zero
  input  logic [gsq_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] gait_phase, [4:3] outer_ankle_mode, [6:5] inner_ankle_mode,
  // [9:7] hip_mode, [10] motors_enabled, [11] gyro_fix, [15:12] zero
  output logic [gsq_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [gsq_pkg::DATA_W-1:0]   pwdata,
  output logic [gsq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import gsq_pkg::*;

  cfg_t              cfg;
  item_t             item_q;
  logic              in_valid;
  result_t           res_d;
  result_t           res_q;
  logic              out_valid;
  phase_t            phase;
  phase_t            phase_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              advance;
  logic              s_acc;

  gsq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsq_step u_step (
    .cfg        (cfg),
    .item       (item_q),
    .phase      (phase),
    .count      (count),
    .phase_next (phase_next),
    .count_next (count_next),
    .res        (res_d)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_SETUP;
      count     <= '0;
    end else begin
      if (s_acc) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;

      if (advance) begin
        out_valid <= 1'b1;
        phase     <= phase_next;
        count     <= count_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      item_q.inner_foot_down <= s_tdata[0];
      item_q.outer_foot_down <= s_tdata[1];
      item_q.hip_angle       <= $signed(s_tdata[HIP_W+1:2]);
    end
    if (advance) res_q <= res_d;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, res_q.gyro_fix, res_q.motors_enabled, res_q.hip_mode,
                     res_q.inner_ankle_mode, res_q.outer_ankle_mode, res_q.gait_phase};

endmodule

@@ rtl/gsq_regs.sv @@
// Configuration register file on the APB-style port.
module gsq_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [gsq_pkg::DATA_W-1:0]   pwdata,
  output logic [gsq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output gsq_pkg::cfg_t                cfg
);
  import gsq_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transition_angle <= ANGLE_RESET;
      cfg.flight_limit     <= LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TRANS_ANGLE:  cfg.transition_angle <= pwdata[ANGLE_W-1:0];
        REG_FLIGHT_LIMIT: cfg.flight_limit     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TRANS_ANGLE:  prdata = {{(DATA_W-ANGLE_W){1'b0}}, cfg.transition_angle};
      REG_FLIGHT_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg.flight_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ rtl/gsq_step.sv @@
// One control tick: airborne counter, phase transition and output modes.
module gsq_step (
  input  gsq_pkg::cfg_t                    cfg,
  input  gsq_pkg::item_t                   item,
  input  gsq_pkg::phase_t                  phase,
  input  logic [gsq_pkg::CNT_W-1:0]        count,
  output gsq_pkg::phase_t                  phase_next,
  output logic [gsq_pkg::CNT_W-1:0]        count_next,
  output gsq_pkg::result_t                 res
);
  import gsq_pkg::*;

  phase_t            ph;
  logic              gyro;
  logic signed [HIP_W:0] hip_x;
  logic signed [HIP_W:0] neg_trans;
  logic signed [HIP_W:0] pos_trans;

  assign hip_x     = {item.hip_angle[HIP_W-1], item.hip_angle};
  assign pos_trans = $signed({{(HIP_W+1-ANGLE_W){1'b0}}, cfg.transition_angle});
  assign neg_trans = -pos_trans;

  always_comb begin
    // unused codes count as flight
    case (phase)
      PH_SETUP, PH_OUT_SWING, PH_OUT_PUSH, PH_INN_SWING, PH_INN_PUSH: ph = phase;
      default: ph = PH_FLIGHT;
    endcase

    count_next = count;
    if (ph != PH_SETUP) begin
      if (!item.inner_foot_down && !item.outer_foot_down) begin
        if (count != {CNT_W{1'b1}}) count_next = count + 1'b1;
      end else begin
        count_next = '0;
      end
      if (count_next >= cfg.flight_limit) ph = PH_FLIGHT;
    end

    gyro       = 1'b0;
    phase_next = ph;
    case (ph)
      PH_SETUP: begin
        if (item.outer_foot_down) phase_next = PH_OUT_SWING;
      end
      PH_OUT_SWING: begin
        if (hip_x < neg_trans) phase_next = PH_OUT_PUSH;
      end
      PH_OUT_PUSH: begin
        if (item.inner_foot_down) begin
          gyro       = 1'b1;
          phase_next = PH_INN_SWING;
        end
      end
      PH_INN_SWING: begin
        if (hip_x > pos_trans) phase_next = PH_INN_PUSH;
      end
      PH_INN_PUSH: begin
        if (item.outer_foot_down) begin
          gyro       = 1'b1;
          phase_next = PH_OUT_SWING;
        end
      end
      default: phase_next = PH_FLIGHT;
    endcase

    res.gait_phase     = phase_next;
    res.motors_enabled = 1'b1;
    res.gyro_fix       = gyro;
    case (phase_next)
      PH_SETUP: begin
        res.outer_ankle_mode = ANK_HOLD;
        res.inner_ankle_mode = ANK_FLIP;
        res.hip_mode         = HIP_ZERO;
      end
      PH_OUT_SWING: begin
        res.outer_ankle_mode = ANK_HOLD;
        res.inner_ankle_mode = ANK_FLIP;
        res.hip_mode         = HIP_SCISSOR_OUTER;
      end
      PH_OUT_PUSH: begin
        res.outer_ankle_mode = ANK_PUSH;
        res.inner_ankle_mode = ANK_HOLD;
        res.hip_mode         = HIP_PLUS_HOLD;
      end
      PH_INN_SWING: begin
        res.outer_ankle_mode = ANK_FLIP;
        res.inner_ankle_mode = ANK_HOLD;
        res.hip_mode         = HIP_SCISSOR_INNER;
      end
      PH_INN_PUSH: begin
        res.outer_ankle_mode = ANK_HOLD;
        res.inner_ankle_mode = ANK_PUSH;
        res.hip_mode         = HIP_MINUS_HOLD;
      end
      default: begin
        res.outer_ankle_mode = ANK_HOLD;
        res.inner_ankle_mode = ANK_HOLD;
        res.hip_mode         = HIP_ZERO;
        res.motors_enabled   = 1'b0;
        res.gyro_fix         = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/gsq_checker.sv @@
// Port-level checks for the gait sequencer, bound to the top level.
module gsq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [gsq_pkg::OUT_W-1:0]  m_tdata
);
  import gsq_pkg::*;

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // motors off exactly in flight
  a_motors: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10] == (m_tdata[2:0] != PH_FLIGHT)))
    else $error("motor enable disagrees with phase");

  // gyro correction only on landing into a swing
  a_gyro: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |->
      (m_tdata[2:0] == PH_OUT_SWING) || (m_tdata[2:0] == PH_INN_SWING))
    else $error("gyro fix outside a swing phase");

endmodule

bind biped_gait_sequencer_unit gsq_checker u_gsq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ bench/biped_gait_sequencer_unit_tb.sv @@
// Stimulus and checking for the biped gait sequencer: directed ticks, random walking, flight.
module biped_gait_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    item_t   tick;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // [0] inner_foot_down, [1] outer_foot_down, [17:2] hip_angle
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;   // [2:0] phase, [4:3] outer ankle, [6:5] inner ankle,
                                  // [9:7] hip mode, [10] motors, [11] gyro_fix
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // gait model state
  phase_t              cur_phase;
  logic [CNT_W-1:0]    air_cnt;
  logic [ANGLE_W-1:0]  cfg_angle;
  logic [LIMIT_W-1:0]  cfg_limit;

  result_t             queued_gaits[$];
  dir_row_t            dir_rows[20];
  int                  err_cnt;
  int                  cyc;
  int                  rcv_stall;
  bit                  hold_req;
  int                  hold_left;

  biped_gait_sequencer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cyc);
    err_cnt++;
  endtask

  // one control tick of the walking cycle
  function automatic result_t gait_tick(input item_t it);
    int      hip;
    int      trans;
    phase_t  ph;
    result_t r;
    hip   = int'($signed(it.hip_angle));
    trans = int'(cfg_angle);
    ph    = cur_phase;
    r.gyro_fix = 1'b0;
    if (ph != PH_SETUP) begin
      if (!it.inner_foot_down && !it.outer_foot_down) begin
        if (air_cnt != {CNT_W{1'b1}}) air_cnt = air_cnt + 1'b1;
      end else begin
        air_cnt = '0;
      end
      if (air_cnt >= cfg_limit) ph = PH_FLIGHT;
    end
    case (ph)
      PH_SETUP:     if (it.outer_foot_down) ph = PH_OUT_SWING;
      PH_OUT_SWING: if (hip < -trans) ph = PH_OUT_PUSH;
      PH_OUT_PUSH: begin
        if (it.inner_foot_down) begin
          r.gyro_fix = 1'b1;
          ph = PH_INN_SWING;
        end
      end
      PH_INN_SWING: if (hip > trans) ph = PH_INN_PUSH;
      PH_INN_PUSH: begin
        if (it.outer_foot_down) begin
          r.gyro_fix = 1'b1;
          ph = PH_OUT_SWING;
        end
      end
      default:      ph = PH_FLIGHT;
    endcase
    cur_phase = ph;
    r.gait_phase     = ph;
    r.motors_enabled = 1'b1;
    case (ph)
      PH_SETUP: begin
        r.outer_ankle_mode = ANK_HOLD; r.inner_ankle_mode = ANK_FLIP; r.hip_mode = HIP_ZERO;
      end
      PH_OUT_SWING: begin
        r.outer_ankle_mode = ANK_HOLD; r.inner_ankle_mode = ANK_FLIP;
        r.hip_mode = HIP_SCISSOR_OUTER;
      end
      PH_OUT_PUSH: begin
        r.outer_ankle_mode = ANK_PUSH; r.inner_ankle_mode = ANK_HOLD; r.hip_mode = HIP_PLUS_HOLD;
      end
      PH_INN_SWING: begin
        r.outer_ankle_mode = ANK_FLIP; r.inner_ankle_mode = ANK_HOLD;
        r.hip_mode = HIP_SCISSOR_INNER;
      end
      PH_INN_PUSH: begin
        r.outer_ankle_mode = ANK_HOLD; r.inner_ankle_mode = ANK_PUSH;
        r.hip_mode = HIP_MINUS_HOLD;
      end
      default: begin
        r.outer_ankle_mode = ANK_HOLD; r.inner_ankle_mode = ANK_HOLD; r.hip_mode = HIP_ZERO;
        r.motors_enabled = 1'b0; r.gyro_fix = 1'b0;
      end
    endcase
    return r;
  endfunction

  // entered and left just after a falling edge, with nothing yet driven in that step
  task automatic send_tick(input item_t it, input bit typed, input result_t want);
    result_t pred;
    s_tdata  <= {{(IN_W-HIP_W-2){1'b0}}, it.hip_angle, it.outer_foot_down, it.inner_foot_down};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = gait_tick(it);
    queued_gaits.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch("register readback", int'(prdata), int'(want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    if (idx == REG_TRANS_ANGLE) cfg_angle = value[ANGLE_W-1:0];
    else                        cfg_limit = value[LIMIT_W-1:0];
    check_reg(idx, idx == REG_TRANS_ANGLE ? DATA_W'(cfg_angle) : DATA_W'(cfg_limit));
  endtask

  // leave the block idle: input closed, every result delivered, pipeline flushed
  task automatic drain;
    s_tvalid <= 1'b0;
    while (queued_gaits.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random ticks; mostly steered along the walking cycle; both feet up at the limit avoided unless all airborne
  task automatic run_phase(input int n, input int snd_idle, input int rcv_pct, input bit airborne);
    item_t   it;
    int      h;
    int      trans;
    int      gap;
    result_t none;
    none = '0;
    rcv_stall = rcv_pct;
    for (int i = 0; i < n; i++) begin
      trans = int'(cfg_angle);
      it.inner_foot_down = 1'($urandom_range(0, 1));
      it.outer_foot_down = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: h = int'($urandom_range(0, 65535)) - 32768;
        1: h = ($urandom_range(0, 1) ? trans : -trans) + int'($urandom_range(0, 4)) - 2;
        2: h = $urandom_range(0, 1) ? 32767 : -32768;
        default: h = int'($urandom_range(0, 600)) - 300;
      endcase
      if ($urandom_range(0, 99) < 70) begin
        case (cur_phase)
          PH_SETUP, PH_INN_PUSH: it.outer_foot_down = 1'b1;
          PH_OUT_SWING: h = -trans - 1 - int'($urandom_range(0, 3));
          PH_OUT_PUSH:  it.inner_foot_down = 1'b1;
          PH_INN_SWING: h = trans + 1 + int'($urandom_range(0, 3));
          default: ;
        endcase
      end
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      it.hip_angle = 16'(h);
      if (airborne) begin
        it.inner_foot_down = 1'b0;
        it.outer_foot_down = 1'b0;
      end else if (!it.inner_foot_down && !it.outer_foot_down &&
                   int'(air_cnt) + 1 >= int'(cfg_limit)) begin
        if ($urandom_range(0, 1)) it.inner_foot_down = 1'b1;
        else                      it.outer_foot_down = 1'b1;
      end
      send_tick(it, 1'b0, none);
      gap = 0;
      while ($urandom_range(0, 99) < snd_idle) gap++;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (queued_gaits.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_tdata), 0);
      end else begin
        want = queued_gaits.pop_front();
        if (m_tdata[2:0] !== want.gait_phase)
          report_mismatch("gait_phase", int'(m_tdata[2:0]), int'(want.gait_phase));
        if (m_tdata[4:3] !== want.outer_ankle_mode)
          report_mismatch("outer_ankle_mode", int'(m_tdata[4:3]), int'(want.outer_ankle_mode));
        if (m_tdata[6:5] !== want.inner_ankle_mode)
          report_mismatch("inner_ankle_mode", int'(m_tdata[6:5]), int'(want.inner_ankle_mode));
        if (m_tdata[9:7] !== want.hip_mode)
          report_mismatch("hip_mode", int'(m_tdata[9:7]), int'(want.hip_mode));
        if (m_tdata[10] !== want.motors_enabled)
          report_mismatch("motors_enabled", int'(m_tdata[10]), int'(want.motors_enabled));
        if (m_tdata[11] !== want.gyro_fix)
          report_mismatch("gyro_fix", int'(m_tdata[11]), int'(want.gyro_fix));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    err_cnt   = 0;
    cyc       = 0;
    rcv_stall = 0;
    hold_req  = 1'b0;
    cur_phase = PH_SETUP;
    air_cnt   = '0;
    cfg_angle = ANGLE_RESET;
    cfg_limit = LIMIT_RESET;

    dir_rows = '{
      // setup holds while the outer feet are up, whatever else happens
      '{'{1'b0, 1'b0, 16'h7fff}, 1'b1,
        '{PH_SETUP, ANK_HOLD, ANK_FLIP, HIP_ZERO, 1'b1, 1'b0}},
      '{'{1'b1, 1'b0, 16'h8000}, 1'b1,
        '{PH_SETUP, ANK_HOLD, ANK_FLIP, HIP_ZERO, 1'b1, 1'b0}},
      // leaving setup: no gyro pulse
      '{'{1'b0, 1'b1, 16'h0000}, 1'b1,
        '{PH_OUT_SWING, ANK_HOLD, ANK_FLIP, HIP_SCISSOR_OUTER, 1'b1, 1'b0}},
      '{'{1'b0, 1'b0, 16'hfeb8}, 1'b0, '0},   // exactly -328: stays in swing
      '{'{1'b0, 1'b0, 16'hfeb7}, 1'b0, '0},
      '{'{1'b0, 1'b0, 16'h7fff}, 1'b0, '0},
      '{'{1'b1, 1'b0, 16'h0000}, 1'b0, '0},   // landing: gyro pulse
      '{'{1'b1, 1'b1, 16'h0148}, 1'b0, '0},   // exactly +328: stays
      '{'{1'b1, 1'b0, 16'h0149}, 1'b0, '0},
      '{'{1'b1, 1'b0, 16'h8000}, 1'b0, '0},
      '{'{1'b0, 1'b1, 16'h7fff}, 1'b0, '0},
      '{'{1'b1, 1'b1, 16'h8000}, 1'b0, '0},
      '{'{1'b1, 1'b1, 16'h0000}, 1'b0, '0},
      '{'{1'b0, 1'b0, 16'h7fff}, 1'b0, '0},
      '{'{1'b0, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{1'b1, 1'b1, 16'hffff}, 1'b0, '0},
      '{'{1'b1, 1'b0, 16'h8001}, 1'b0, '0},
      '{'{1'b0, 1'b1, 16'h0001}, 1'b0, '0},
      '{'{1'b1, 1'b1, 16'h5555}, 1'b0, '0},
      '{'{1'b0, 1'b1, 16'haaaa}, 1'b0, '0}
    };

    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    check_reg(REG_TRANS_ANGLE, DATA_W'(ANGLE_RESET));
    check_reg(REG_FLIGHT_LIMIT, DATA_W'(LIMIT_RESET));

    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // no idling, opened by a long receiver hold-off so the input stage backs up
    cfg_write(REG_TRANS_ANGLE, 32'd0);
    cfg_write(REG_FLIGHT_LIMIT, 32'd65535);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    run_phase(225, 0, 0, 1'b0);

    // widest angle; limit of one tick means both feet never leave together
    cfg_write(REG_TRANS_ANGLE, 32'd32767);
    cfg_write(REG_FLIGHT_LIMIT, 32'd1);
    run_phase(100, 64, 0, 1'b0);

    cfg_write(REG_TRANS_ANGLE, DATA_W'($urandom_range(0, 4095)));
    cfg_write(REG_FLIGHT_LIMIT, 32'd3);
    run_phase(225, 0, 64, 1'b0);

    cfg_write(REG_TRANS_ANGLE, 32'd328);
    cfg_write(REG_FLIGHT_LIMIT, 32'd200);
    run_phase(225, 26, 26, 1'b0);

    cfg_write(REG_TRANS_ANGLE, DATA_W'($urandom_range(0, 32767)));
    cfg_write(REG_FLIGHT_LIMIT, DATA_W'($urandom_range(2, 300)));
    run_phase(100, 0, 0, 1'b0);

    // flight is absorbing, so it comes last: stay airborne up to the limit and past it
    cfg_write(REG_FLIGHT_LIMIT, 32'd16);
    run_phase(30, 0, 0, 1'b1);
    cfg_write(REG_FLIGHT_LIMIT, 32'd0);
    run_phase(12, 26, 26, 1'b0);

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
